// File: hdl/nfba_pkg.sv
// Shared constants, request/status codes and state type for the block allocator.
`default_nettype none
package nfba_pkg;

  localparam int MAX_BLOCKS = 256;
  localparam int WORD_BITS  = 32;
  localparam int MAP_WORDS  = MAX_BLOCKS / WORD_BITS;
  localparam int WORD_AW    = $clog2(MAP_WORDS);
  localparam int BIT_AW     = $clog2(WORD_BITS);
  localparam int BLK_W      = 8;
  localparam int CNT_W      = WORD_AW + 1;
  localparam int REQ_W      = 3;
  localparam int STAT_W     = 2;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;

  localparam logic [BLK_W-1:0] NUM_BLOCKS_RST  = 8'd252;
  localparam logic [BLK_W-1:0] START_BLOCK_RST = 8'd0;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC  = 3'd0,
    REQ_MARK   = 3'd1,
    REQ_FREE   = 3'd2,
    REQ_TEST   = 3'd3,
    REQ_COMMIT = 3'd4,
    REQ_ABORT  = 3'd5,
    REQ_INIT   = 3'd6
  } nfba_req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } nfba_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ONE,
    S_COPY,
    S_DONE
  } nfba_state_t;

  // register selects (paddr bit 2)
  localparam logic REG_NUM_BLOCKS  = 1'b0;
  localparam logic REG_START_BLOCK = 1'b1;

endpackage
`default_nettype wire

// File: hdl/nfba_req_if.sv
// Request channel: valid/ready handshake carrying request type and block index.
`default_nettype none
interface nfba_req_if;
  logic                          valid;
  logic                          ready;
  logic [nfba_pkg::REQ_W-1:0]    req_type;
  logic [nfba_pkg::BLK_W-1:0]    block_index;

  modport source (output valid, output req_type, output block_index, input ready);
  modport sink   (input valid, input req_type, input block_index, output ready);
endinterface
`default_nettype wire

// File: hdl/nfba_res_if.sv
// Result channel: valid/ready handshake carrying status, granted block and used bit.
`default_nettype none
interface nfba_res_if;
  logic                          valid;
  logic                          ready;
  logic [nfba_pkg::STAT_W-1:0]   status;
  logic [nfba_pkg::BLK_W-1:0]    granted_block;
  logic                          is_used;

  modport source (output valid, output status, output granted_block, output is_used, input ready);
  modport sink   (input valid, input status, input granted_block, input is_used, output ready);
endinterface
`default_nettype wire

// File: hdl/next_fit_bitmap_block_allocator.sv
// Next-fit block allocator: working and committed used-bit maps in two word-wide
// memories, a rotating next pointer and an APB register port. One request is worked
// at a time. Alloc reads one word of the working map per cycle, with up to nine word
// visits around the ring, stopping at the first free block; mark and free do one
// read-modify-write and test one read; commit and abort copy the eight words one per
// cycle between the two memories; init and the unused code go straight to S_DONE.
// A finished result waits until the output register is free, is then loaded into it
// and the block returns to idle. Map words carry reset-cleared valid bits, so reset
// and init take effect at once with no clearing pass.
`default_nettype none
module next_fit_bitmap_block_allocator (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  nfba_req_if.sink                           in_req,
  nfba_res_if.source                         out_res,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [nfba_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [nfba_pkg::CFG_DW-1:0]   pwdata,
  output logic      [nfba_pkg::CFG_DW-1:0]   prdata,
  output logic                               pready
);

  localparam int WB = nfba_pkg::WORD_BITS;
  localparam int WA = nfba_pkg::WORD_AW;
  localparam int BA = nfba_pkg::BIT_AW;
  localparam int BW = nfba_pkg::BLK_W;
  localparam int CW = nfba_pkg::CNT_W;
  localparam int NW = nfba_pkg::MAP_WORDS;

  // configuration registers
  logic [BW-1:0] num_blocks_r, start_block_r;
  logic          cfg_wr;

  // map memories
  logic [WB-1:0] wmap_mem [NW];
  logic [WB-1:0] cmap_mem [NW];
  logic [WB-1:0] wm_q_r, cm_q_r;
  logic          wm_qv_r, cm_qv_r;
  logic [NW-1:0] wvld_r, wvld_nxt, cvld_r, cvld_nxt;
  logic [WA-1:0] wm_raddr, cm_raddr, wm_waddr, cm_waddr;
  logic          wm_we, cm_we;
  logic [WB-1:0] wm_wdata, cm_wdata, wm_rd, cm_rd;

  // control
  nfba_pkg::nfba_state_t state_r, state_nxt;
  logic [CW-1:0]           k_r, k_nxt;
  logic [nfba_pkg::REQ_W-1:0] req_r, req_nxt;
  logic [BW-1:0]           idx_r, idx_nxt;
  logic [BW-1:0]           pos_r, pos_nxt;
  logic                    excl_r, excl_nxt;
  logic [BW-1:0]           next_ptr_r, next_ptr_nxt;
  logic [nfba_pkg::STAT_W-1:0] res_status_r, res_status_nxt;
  logic [BW-1:0]           res_granted_r, res_granted_nxt;
  logic                    res_used_r, res_used_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [nfba_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic [BW-1:0]           out_granted_r, out_granted_nxt;
  logic                    out_used_r, out_used_nxt;

  // scan helpers
  logic [BW:0]   np1;
  logic [BW-1:0] pos_c;
  logic          excl_c;
  logic [WA-1:0] scan_word;
  logic [WB-1:0] cand;
  logic          hit;
  logic [BA-1:0] hit_b;
  logic [BW-1:0] blk;
  logic [WA-1:0] k_word;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_blocks_r  <= nfba_pkg::NUM_BLOCKS_RST;
      start_block_r <= nfba_pkg::START_BLOCK_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == nfba_pkg::REG_NUM_BLOCKS) num_blocks_r <= pwdata[BW-1:0];
      else                                      start_block_r <= pwdata[BW-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == nfba_pkg::REG_START_BLOCK) prdata = {{(nfba_pkg::CFG_DW-BW){1'b0}}, start_block_r};
    else                                       prdata = {{(nfba_pkg::CFG_DW-BW){1'b0}}, num_blocks_r};
  end

  // ---------------- map memories ----------------
  always_ff @(posedge clk) begin
    if (wm_we) wmap_mem[wm_waddr] <= wm_wdata;
    wm_q_r <= wmap_mem[wm_raddr];
  end

  always_ff @(posedge clk) begin
    if (cm_we) cmap_mem[cm_waddr] <= cm_wdata;
    cm_q_r <= cmap_mem[cm_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wvld_r  <= '0;
      cvld_r  <= '0;
      wm_qv_r <= 1'b0;
      cm_qv_r <= 1'b0;
    end else begin
      wvld_r  <= wvld_nxt;
      cvld_r  <= cvld_nxt;
      wm_qv_r <= wvld_r[wm_raddr];
      cm_qv_r <= cvld_r[cm_raddr];
    end
  end

  // words not written since reset or init read as free
  assign wm_rd = wm_qv_r ? wm_q_r : '0;
  assign cm_rd = cm_qv_r ? cm_q_r : '0;

  // ---------------- scan logic ----------------
  assign np1    = {1'b0, next_ptr_r} + {{BW{1'b0}}, 1'b1};
  assign pos_c  = (np1 >= {1'b0, num_blocks_r}) ? '0 : np1[BW-1:0];
  assign excl_c = (next_ptr_r < num_blocks_r) && (num_blocks_r > {{(BW-1){1'b0}}, 1'b1});

  assign k_word    = k_r[WA-1:0];
  // visit k covers word pos+k; the ninth visit returns to the start word, low bits only
  assign scan_word = pos_r[BW-1:BA] + k_word;

  always_comb begin
    for (int b = 0; b < WB; b++) begin
      blk = {scan_word, BA'(b)};
      cand[b] = !wm_rd[b] && (blk < num_blocks_r) && !(excl_r && (blk == next_ptr_r));
      if (k_r == '0)
        cand[b] = cand[b] && (BA'(b) >= pos_r[BA-1:0]);
      else if (k_r == CW'(NW))
        cand[b] = cand[b] && (BA'(b) < pos_r[BA-1:0]);
    end
  end

  always_comb begin
    hit_b = '0;
    for (int b = WB - 1; b >= 0; b--) begin
      if (cand[b]) hit_b = BA'(b);
    end
  end

  assign hit = |cand;

  // ---------------- state machine ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nfba_pkg::S_IDLE;
      next_ptr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      next_ptr_r  <= next_ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r           <= k_nxt;
    req_r         <= req_nxt;
    idx_r         <= idx_nxt;
    pos_r         <= pos_nxt;
    excl_r        <= excl_nxt;
    res_status_r  <= res_status_nxt;
    res_granted_r <= res_granted_nxt;
    res_used_r    <= res_used_nxt;
    out_status_r  <= out_status_nxt;
    out_granted_r <= out_granted_nxt;
    out_used_r    <= out_used_nxt;
  end

  assign in_req.ready          = (state_r == nfba_pkg::S_IDLE);
  assign out_res.valid         = out_valid_r;
  assign out_res.status        = out_status_r;
  assign out_res.granted_block = out_granted_r;
  assign out_res.is_used       = out_used_r;

  always_comb begin
    state_nxt       = state_r;
    k_nxt           = k_r;
    req_nxt         = req_r;
    idx_nxt         = idx_r;
    pos_nxt         = pos_r;
    excl_nxt        = excl_r;
    next_ptr_nxt    = next_ptr_r;
    res_status_nxt  = res_status_r;
    res_granted_nxt = res_granted_r;
    res_used_nxt    = res_used_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_granted_nxt = out_granted_r;
    out_used_nxt    = out_used_r;
    wvld_nxt        = wvld_r;
    cvld_nxt        = cvld_r;
    wm_raddr        = '0;
    cm_raddr        = '0;
    wm_we           = 1'b0;
    cm_we           = 1'b0;
    wm_waddr        = '0;
    cm_waddr        = '0;
    wm_wdata        = '0;
    cm_wdata        = '0;

    if (out_valid_r && out_res.ready) out_valid_nxt = 1'b0;

    case (state_r)
      nfba_pkg::S_IDLE: begin
        if (in_req.valid) begin
          req_nxt         = in_req.req_type;
          idx_nxt         = in_req.block_index;
          k_nxt           = '0;
          res_status_nxt  = nfba_pkg::ST_OK;
          res_granted_nxt = in_req.block_index;
          res_used_nxt    = 1'b0;
          case (nfba_pkg::nfba_req_t'(in_req.req_type))
            nfba_pkg::REQ_ALLOC: begin
              pos_nxt   = pos_c;
              excl_nxt  = excl_c;
              wm_raddr  = pos_c[BW-1:BA];
              state_nxt = nfba_pkg::S_SCAN;
            end
            nfba_pkg::REQ_MARK, nfba_pkg::REQ_FREE, nfba_pkg::REQ_TEST: begin
              wm_raddr  = in_req.block_index[BW-1:BA];
              state_nxt = nfba_pkg::S_ONE;
            end
            nfba_pkg::REQ_COMMIT, nfba_pkg::REQ_ABORT: begin
              wm_raddr  = '0;
              cm_raddr  = '0;
              state_nxt = nfba_pkg::S_COPY;
            end
            nfba_pkg::REQ_INIT: begin
              wvld_nxt     = '0;
              cvld_nxt     = '0;
              next_ptr_nxt = start_block_r;
              state_nxt    = nfba_pkg::S_DONE;
            end
            default: begin
              state_nxt = nfba_pkg::S_DONE;
            end
          endcase
        end
      end

      nfba_pkg::S_SCAN: begin
        if (hit) begin
          wm_we           = 1'b1;
          wm_waddr        = scan_word;
          wm_wdata        = wm_rd;
          wm_wdata[hit_b] = 1'b1;
          next_ptr_nxt    = {scan_word, hit_b};
          res_granted_nxt = {scan_word, hit_b};
          state_nxt       = nfba_pkg::S_DONE;
        end else if (k_r == CW'(NW)) begin
          res_status_nxt = nfba_pkg::ST_FULL;
          state_nxt      = nfba_pkg::S_DONE;
        end else begin
          k_nxt    = k_r + CW'(1);
          wm_raddr = pos_r[BW-1:BA] + k_nxt[WA-1:0];
        end
      end

      nfba_pkg::S_ONE: begin
        if (idx_r >= num_blocks_r) begin
          res_status_nxt = nfba_pkg::ST_RANGE;
        end else begin
          res_used_nxt = wm_rd[idx_r[BA-1:0]];
          wm_waddr     = idx_r[BW-1:BA];
          wm_wdata     = wm_rd;
          if (req_r == nfba_pkg::REQ_MARK) begin
            wm_we                    = 1'b1;
            wm_wdata[idx_r[BA-1:0]]  = 1'b1;
          end else if (req_r == nfba_pkg::REQ_FREE) begin
            wm_we                    = 1'b1;
            wm_wdata[idx_r[BA-1:0]]  = 1'b0;
          end
        end
        state_nxt = nfba_pkg::S_DONE;
      end

      nfba_pkg::S_COPY: begin
        // read word k+1 of the source while word k goes into the destination
        k_nxt = k_r + CW'(1);
        if (req_r == nfba_pkg::REQ_COMMIT) begin
          cm_we    = 1'b1;
          cm_waddr = k_word;
          cm_wdata = wm_rd;
          wm_raddr = k_nxt[WA-1:0];
        end else begin
          wm_we    = 1'b1;
          wm_waddr = k_word;
          wm_wdata = cm_rd;
          cm_raddr = k_nxt[WA-1:0];
        end
        if (k_word == WA'(NW - 1)) state_nxt = nfba_pkg::S_DONE;
      end

      nfba_pkg::S_DONE: begin
        if (!out_valid_r || out_res.ready) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_granted_nxt = res_granted_r;
          out_used_nxt    = res_used_r;
          state_nxt       = nfba_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = nfba_pkg::S_IDLE;
      end
    endcase

    if (wm_we) wvld_nxt[wm_waddr] = 1'b1;
    if (cm_we) cvld_nxt[cm_waddr] = 1'b1;
  end

  // ---------------- assertions ----------------
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nfba_pkg::S_SCAN) |-> (k_r <= CW'(NW)))
    else $error("scan visit count overran");

  a_grant_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nfba_pkg::S_SCAN && hit) |=> (next_ptr_r < num_blocks_r))
    else $error("granted block outside managed range");

  a_one_map_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(wm_we && cm_we))
    else $error("both maps written in one cycle");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> (state_r != nfba_pkg::S_IDLE))
    else $error("accepted transaction left no trace in the state machine");

  a_result_not_overwritten: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res.ready) |=> (out_valid_r && $stable(out_granted_r)))
    else $error("pending result overwritten");

endmodule
`default_nettype wire
